// ===== src/btm_pkg.sv =====
// Shared constants, codes and types of the binary trie multiset.
// No dependencies; the top and btm_core refer to this package, btm_ram does not.
package btm_pkg;

	localparam int VALUE_BITS  = 10;
	localparam int COUNT_BITS  = 16;
	localparam int RANK_BITS   = 16;
	localparam int CMD_BITS    = 3;
	localparam int STATUS_BITS = 2;

	// One memory row holds a sibling pair: node 2r in the low half, 2r+1 in the high half.
	localparam int ROW_BITS = VALUE_BITS;
	localparam int ROW_W    = 2 * COUNT_BITS;

	localparam int LVL_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int CMP_BITS = (COUNT_BITS > RANK_BITS) ? COUNT_BITS : RANK_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [LVL_BITS-1:0]   LVL_TOP   = LVL_BITS'(VALUE_BITS - 1);

	typedef enum logic [CMD_BITS-1:0] {
		CMD_INSERT   = 3'd0,
		CMD_ERASE    = 3'd1,
		CMD_MIN_XOR  = 3'd2,
		CMD_MAX_XOR  = 3'd3,
		CMD_COUNT_LT = 3'd4,
		CMD_COUNT_LE = 3'd5,
		CMD_KTH      = 3'd6,
		CMD_COUNT_EQ = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PLAN,
		S_WALK,
		S_FIN
	} state_t;

	typedef struct packed {
		logic                rd_en;
		logic [ROW_BITS-1:0] rd_addr;
		logic                wr_en;
		logic [ROW_BITS-1:0] wr_addr;
		logic [ROW_W-1:0]    wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [COUNT_BITS-1:0] count;
		status_t               status;
	} result_t;

endpackage

// ===== src/binary_trie_multiset.sv =====
// Binary trie multiset: count memory, command sequencer and output register.
// Walking commands step through the trie one level per cycle, set by the dependent read
// of the single count-memory read port; count-equal and rejected commands skip the walk.
// A new command is taken only after the previous result has passed to the output register.
// Reset: a clearing sweep writes 2^VALUE_BITS rows with in_ready low, then the set is empty.
module binary_trie_multiset (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [btm_pkg::CMD_BITS-1:0]      cmd,
	input  logic [btm_pkg::VALUE_BITS-1:0]    value,
	input  logic [btm_pkg::RANK_BITS-1:0]     rank,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [btm_pkg::VALUE_BITS-1:0]    value_out,
	output logic [btm_pkg::COUNT_BITS-1:0]    count_out,
	output logic [btm_pkg::STATUS_BITS-1:0]   status
);

	btm_pkg::mem_req_t             mem_req;
	logic [btm_pkg::ROW_W-1:0]     mem_rd_data;
	btm_pkg::result_t              res;
	logic                          res_valid, res_take;
	logic                          out_valid_q;
	btm_pkg::result_t              out_q;

	// Per-prefix counts, stored as sibling pairs so one read yields both children.
	btm_ram #(
		.ADDR_BITS(btm_pkg::ROW_BITS),
		.DATA_BITS(btm_pkg::ROW_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (mem_req.wr_en),
		.wr_addr(mem_req.wr_addr),
		.wr_data(mem_req.wr_data),
		.rd_en  (mem_req.rd_en),
		.rd_addr(mem_req.rd_addr),
		.rd_data(mem_rd_data)
	);

	// Walks the trie top bit first, one level per cycle.
	btm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_cmd     (cmd),
		.in_value   (value),
		.in_rank    (rank),
		.mem_req    (mem_req),
		.mem_rd_data(mem_rd_data),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	// Output register: hand over a result when the slot is empty or draining,
	// so the core can take the next item while a result waits downstream.
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = out_q.value;
	assign count_out = out_q.count;
	assign status    = out_q.status;

endmodule

// ===== src/btm_ram.sv =====
// Generic simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No dependencies.
module btm_ram #(
	parameter int ADDR_BITS = 10,
	parameter int DATA_BITS = 32
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [DATA_BITS-1:0] rd_data
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/btm_core.sv =====
// Command sequencer and trie walk datapath of the binary trie multiset.
// Depends on btm_pkg; drives the count memory through a btm_pkg::mem_req_t.
module btm_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [btm_pkg::CMD_BITS-1:0]        in_cmd,
	input  logic [btm_pkg::VALUE_BITS-1:0]      in_value,
	input  logic [btm_pkg::RANK_BITS-1:0]       in_rank,
	output btm_pkg::mem_req_t                   mem_req,
	input  logic [btm_pkg::ROW_W-1:0]           mem_rd_data,
	output logic                                res_valid,
	input  logic                                res_take,
	output btm_pkg::result_t                    res
);

	localparam int VB = btm_pkg::VALUE_BITS;
	localparam int CB = btm_pkg::COUNT_BITS;

	btm_pkg::state_t  state_q, state_d;
	btm_pkg::cmd_t    cmd_q;
	btm_pkg::status_t st_q;

	logic [VB-1:0]                     val_q;
	logic [btm_pkg::RANK_BITS-1:0]     rank_q;
	logic [CB-1:0]                     k_q, total_q, leaf_q, size_q;
	logic [VB:0]                       n_q;
	logic [btm_pkg::LVL_BITS-1:0]      lvl_q;
	logic [btm_pkg::ROW_BITS-1:0]      clr_q;

	logic [CB-1:0]     lo, hi, leaf, child_b, child_old, child_new, size_new;
	logic              b, f, plan_walk;
	btm_pkg::status_t  plan_st;
	logic [VB:0]       n_next;
	logic [VB:0]       in_node;

	assign lo      = mem_rd_data[CB-1:0];
	assign hi      = mem_rd_data[btm_pkg::ROW_W-1:CB];
	assign leaf    = val_q[0] ? hi : lo;
	assign b       = val_q[VB-1];
	assign child_b = b ? hi : lo;
	assign in_node = {1'b1, in_value};

	// Decide whether the command walks the trie, and its error status.
	always_comb begin
		plan_st   = btm_pkg::ST_OK;
		plan_walk = 1'b0;
		unique case (cmd_q)
			btm_pkg::CMD_INSERT: begin
				if (size_q == btm_pkg::COUNT_MAX) begin
					plan_st = btm_pkg::ST_FULL;
				end else begin
					plan_walk = 1'b1;
				end
			end
			btm_pkg::CMD_ERASE: begin
				if (leaf == '0) begin
					plan_st = btm_pkg::ST_MISS;
				end else begin
					plan_walk = 1'b1;
				end
			end
			btm_pkg::CMD_MIN_XOR, btm_pkg::CMD_MAX_XOR: begin
				if (size_q == '0) begin
					plan_st = btm_pkg::ST_MISS;
				end else begin
					plan_walk = 1'b1;
				end
			end
			btm_pkg::CMD_COUNT_LT, btm_pkg::CMD_COUNT_LE: begin
				plan_walk = 1'b1;
			end
			btm_pkg::CMD_KTH: begin
				if (btm_pkg::CMP_BITS'(rank_q) >= btm_pkg::CMP_BITS'(size_q)) begin
					plan_st = btm_pkg::ST_MISS;
				end else begin
					plan_walk = 1'b1;
				end
			end
			btm_pkg::CMD_COUNT_EQ: begin
				plan_walk = 1'b0;
			end
		endcase
	end

	// Pick the branch taken at the current level.
	always_comb begin
		unique case (cmd_q)
			btm_pkg::CMD_MIN_XOR, btm_pkg::CMD_MAX_XOR: f = (child_b == '0) ? ~b : b;
			btm_pkg::CMD_KTH:                          f = !(k_q < lo);
			default:                                   f = b;
		endcase
		n_next    = {n_q[VB-1:0], f};
		child_old = f ? hi : lo;
		child_new = (cmd_q == btm_pkg::CMD_INSERT) ? child_old + 1'b1 : child_old - 1'b1;
		size_new  = (cmd_q == btm_pkg::CMD_INSERT) ? size_q + 1'b1 : size_q - 1'b1;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btm_pkg::S_CLEAR: if (clr_q == '1) state_d = btm_pkg::S_IDLE;
			btm_pkg::S_IDLE:  if (in_valid) state_d = btm_pkg::S_PLAN;
			btm_pkg::S_PLAN:  state_d = plan_walk ? btm_pkg::S_WALK : btm_pkg::S_FIN;
			btm_pkg::S_WALK:  if (lvl_q == '0) state_d = btm_pkg::S_FIN;
			btm_pkg::S_FIN:   if (res_take) state_d = btm_pkg::S_IDLE;
		endcase
	end

	// Outputs: memory requests and handshakes.
	always_comb begin
		mem_req   = '0;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			btm_pkg::S_CLEAR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = clr_q;
			end
			btm_pkg::S_IDLE: begin
				in_ready        = 1'b1;
				mem_req.rd_en   = in_valid;
				mem_req.rd_addr = in_node[VB:1];
			end
			btm_pkg::S_PLAN: begin
				// Root count lives in row zero next to the unused node zero.
				mem_req.rd_en   = plan_walk;
				mem_req.rd_addr = btm_pkg::ROW_BITS'(1);
				mem_req.wr_en   = plan_walk && (cmd_q == btm_pkg::CMD_INSERT ||
				                                cmd_q == btm_pkg::CMD_ERASE);
				mem_req.wr_addr = '0;
				mem_req.wr_data = {size_new, CB'(0)};
			end
			btm_pkg::S_WALK: begin
				mem_req.rd_en   = (lvl_q != '0);
				mem_req.rd_addr = n_next[VB-1:0];
				mem_req.wr_en   = (cmd_q == btm_pkg::CMD_INSERT ||
				                   cmd_q == btm_pkg::CMD_ERASE);
				mem_req.wr_addr = n_q[VB-1:0];
				mem_req.wr_data = f ? {child_new, lo} : {hi, child_new};
			end
			btm_pkg::S_FIN: begin
				res_valid = 1'b1;
			end
		endcase
	end

	// Result of the finished command.
	always_comb begin
		res.status = st_q;
		res.value  = '0;
		if (st_q == btm_pkg::ST_OK && (cmd_q == btm_pkg::CMD_MIN_XOR ||
		    cmd_q == btm_pkg::CMD_MAX_XOR || cmd_q == btm_pkg::CMD_KTH)) begin
			res.value = n_q[VB-1:0];
		end
		unique case (cmd_q)
			btm_pkg::CMD_COUNT_LT: res.count = total_q;
			btm_pkg::CMD_COUNT_LE: res.count = total_q + leaf_q;
			btm_pkg::CMD_COUNT_EQ: res.count = leaf_q;
			default:               res.count = size_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btm_pkg::S_CLEAR;
			clr_q   <= '0;
			size_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == btm_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == btm_pkg::S_PLAN && plan_walk &&
			    (cmd_q == btm_pkg::CMD_INSERT || cmd_q == btm_pkg::CMD_ERASE)) begin
				size_q <= size_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			btm_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd_q  <= btm_pkg::cmd_t'(in_cmd);
					val_q  <= in_value;
					rank_q <= in_rank;
				end
			end
			btm_pkg::S_PLAN: begin
				st_q    <= plan_st;
				leaf_q  <= leaf;
				total_q <= '0;
				k_q     <= CB'(rank_q);
				n_q     <= (VB+1)'(1);
				lvl_q   <= btm_pkg::LVL_TOP;
				if (cmd_q == btm_pkg::CMD_MAX_XOR) begin
					val_q <= ~val_q;
				end
			end
			btm_pkg::S_WALK: begin
				n_q   <= n_next;
				lvl_q <= lvl_q - 1'b1;
				val_q <= val_q << 1;
				if (b && (cmd_q == btm_pkg::CMD_COUNT_LT || cmd_q == btm_pkg::CMD_COUNT_LE)) begin
					total_q <= total_q + lo;
				end
				if (cmd_q == btm_pkg::CMD_KTH && f) begin
					k_q <= k_q - lo;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
